// ===== rtl/ffir_pkg.sv =====
// Shared types and constants for the framed FIR filter.
// Used by ffir_cell and framed_fir_filter; depends on nothing.
`default_nettype none

package ffir_pkg;

    localparam int TAPS_MAX    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int RESULT_BITS = 32;
    localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
    localparam int FRAME_BITS  = 16;
    localparam int CFG_BITS    = 16;
    localparam int TAPCNT_BITS = 5;
    localparam int SEL_BITS    = $clog2(TAPS_MAX);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEFF_BITS-1:0]  t_coeff;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic signed [RESULT_BITS-1:0] t_result;

    typedef enum logic [1:0] {
        CFG_TAP_COUNT    = 2'd0,
        CFG_FRAME_LENGTH = 2'd1,
        CFG_COEFF_SELECT = 2'd2,
        CFG_COEFF_VALUE  = 2'd3
    } t_cfg_reg;

    // Strobes broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // accept a sample: move the delay line one cell
        logic clear;   // frame ended: zero the delay line
        logic mul;     // capture the products
        logic adv;     // move the partial sum one cell
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/ffir_cell.sv =====
// One tap of the framed FIR filter: delay slot, coefficient, product and
// partial-sum stage. Depends on ffir_pkg.
`default_nettype none

module ffir_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  ffir_pkg::t_cell_ctrl      i_ctrl,
    input  wire                       i_tap_on,
    input  wire                       i_coeff_we,
    input  ffir_pkg::t_coeff          i_coeff,
    input  ffir_pkg::t_sample         i_sample,
    output ffir_pkg::t_sample         o_sample,
    input  wire                       i_tok,
    input  ffir_pkg::t_result         i_psum,
    output logic                      o_tok,
    output ffir_pkg::t_result         o_psum
);
    import ffir_pkg::*;

    t_sample r_sample;
    t_coeff  r_coeff;
    t_prod   r_prod;
    logic    r_tok;
    t_result r_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_coeff  <= '0;
            r_tok    <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_sample <= '0;
            end else if (i_ctrl.shift) begin
                r_sample <= i_sample;
            end
            if (i_coeff_we) begin
                r_coeff <= i_coeff;
            end
            if (i_ctrl.adv) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= i_tap_on ? t_prod'(r_sample * r_coeff) : '0;
        end
        if (i_ctrl.adv && i_tok) begin
            r_psum <= i_psum + t_result'(r_prod);
        end
    end

    assign o_sample = r_sample;
    assign o_tok    = r_tok;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

// ===== rtl/framed_fir_filter.sv =====
// Top level of the framed FIR filter: configuration registers, frame
// counter, sequencing and output register around a chain of ffir_cell.
// Depends on ffir_pkg and ffir_cell.
//
// Usage:
//   Input channel i_valid / o_stall carries one signed sample per item.
//   Output channel o_valid / i_stall carries o_filtered and o_frame_end.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data:
//   0 tap count (saturates to 1..16), 1 frame length, 2 coefficient
//   select, 3 coefficient value (stored at the selected entry).
//   One item is processed at a time. After acceptance the products are
//   captured, then the partial sum walks the chain of cells, one cell per
//   cycle while the output register is not holding it back. A new item is
//   taken only once the result has been loaded into the output register,
//   after the product stage and the 16-cell sum chain.
//   The output register holds the result while the receiver stalls; the
//   next item may be accepted meanwhile and the chain holds its sum at the
//   last cell until the output register frees.
//   With frame length zero, items are accepted and dropped.
//   Reset clears the delay line, coefficients and frame counter, sets the
//   tap count to 16 and the frame length to zero.
`default_nettype none

module framed_fir_filter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  ffir_pkg::t_sample            i_sample,
    output logic                         o_valid,
    input  wire                          i_stall,
    output ffir_pkg::t_result            o_filtered,
    output logic                         o_frame_end,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_index,
    input  wire  [ffir_pkg::CFG_BITS-1:0] i_cfg_data
);
    import ffir_pkg::*;

    logic [TAPCNT_BITS-1:0] r_tap_count;
    logic [FRAME_BITS-1:0]  r_frame_length;
    logic [SEL_BITS-1:0]    r_coeff_select;
    logic [FRAME_BITS-1:0]  r_position;
    logic                   r_busy;
    logic                   r_mul_pend;
    logic                   r_last;
    logic                   r_go;
    logic                   r_out_valid;
    t_result                r_filtered;
    logic                   r_frame_end;

    logic [TAPCNT_BITS-1:0] n_tap_count;
    logic [FRAME_BITS:0]    n_position;
    logic                   in_accept;
    logic                   take;
    logic                   hold;
    logic                   load;
    t_cell_ctrl             ctrl;

    t_sample                chain_sample [TAPS_MAX+1];
    logic    [TAPS_MAX:0]   chain_tok;
    t_result                chain_psum   [TAPS_MAX+1];

    assign in_accept  = i_valid && !o_stall;
    assign take       = in_accept && (r_frame_length != '0);
    assign n_position = {1'b0, r_position} + (FRAME_BITS+1)'(1);

    // Drain the last cell only when the output register is free
    assign hold = chain_tok[TAPS_MAX] && r_out_valid && i_stall;
    assign load = chain_tok[TAPS_MAX] && !hold;

    always_comb begin
        ctrl.shift = take;
        ctrl.mul   = r_mul_pend;
        ctrl.clear = r_mul_pend && r_last;
        ctrl.adv   = !hold;
    end

    always_comb begin
        n_tap_count = i_cfg_data[TAPCNT_BITS-1:0];
        if (n_tap_count == '0) begin
            n_tap_count = TAPCNT_BITS'(1);
        end else if (n_tap_count > TAPCNT_BITS'(TAPS_MAX)) begin
            n_tap_count = TAPCNT_BITS'(TAPS_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count    <= TAPCNT_BITS'(TAPS_MAX);
            r_frame_length <= '0;
            r_coeff_select <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_TAP_COUNT:    r_tap_count    <= n_tap_count;
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[FRAME_BITS-1:0];
                CFG_COEFF_SELECT: r_coeff_select <= i_cfg_data[SEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_busy      <= 1'b0;
            r_mul_pend  <= 1'b0;
            r_last      <= 1'b0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_pend <= take;
            if (take) begin
                r_busy <= 1'b1;
                if (n_position >= {1'b0, r_frame_length}) begin
                    r_last     <= 1'b1;
                    r_position <= '0;
                end else begin
                    r_last     <= 1'b0;
                    r_position <= n_position[FRAME_BITS-1:0];
                end
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (r_mul_pend) begin
                r_go <= 1'b1;
            end else if (ctrl.adv) begin
                r_go <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_filtered  <= chain_psum[TAPS_MAX];
            r_frame_end <= r_last;
        end
    end

    assign chain_sample[0] = i_sample;
    assign chain_tok[0]    = r_go;
    assign chain_psum[0]   = '0;

    for (genvar g = 0; g < TAPS_MAX; g++) begin : g_cell
        ffir_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_tap_on   (r_tap_count > TAPCNT_BITS'(g)),
            .i_coeff_we (i_cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_COEFF_VALUE)
                         && (r_coeff_select == SEL_BITS'(g))),
            .i_coeff    (t_coeff'(i_cfg_data[COEFF_BITS-1:0])),
            .i_sample   (chain_sample[g]),
            .o_sample   (chain_sample[g+1]),
            .i_tok      (chain_tok[g]),
            .i_psum     (chain_psum[g]),
            .o_tok      (chain_tok[g+1]),
            .o_psum     (chain_psum[g+1])
        );
    end

    assign o_stall     = r_busy;
    assign o_valid     = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_frame_end = r_frame_end;

    // At most one item in flight through the sum chain
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_mul_pend, chain_tok}))
        else $error("more than one item in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (chain_tok == '0) && !r_mul_pend)
        else $error("chain active while idle");

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_mul_pend && r_busy)
        else $error("accepted item did not start");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_valid && !r_busy)
        else $error("result load did not reach output");

endmodule

`default_nettype wire
